FILE: hdl/hhfe_pkg.sv
// Package for the HTTP header field extractor: result codes, field tags,
// parser phase codes, header prefix tables and the result record type.
// No dependencies; used by every file of the block.
`timescale 1ns / 1ps
`default_nettype none

package hhfe_pkg;

  // Width of the Content-Length accumulator.
  localparam int LENGTH_BITS = 32;

  // Output beat layout.
  localparam int TDATA_OUT_BITS = 56;
  localparam int TDATA_IN_BITS  = 8;

  typedef enum logic [1:0] {
    RES_BYTE    = 2'd0,
    RES_END     = 2'd1,
    RES_SUMMARY = 2'd2
  } res_kind_e;

  // Field tags.
  localparam logic [2:0] TAG_TOKEN0 = 3'd0;
  localparam logic [2:0] TAG_TOKEN1 = 3'd1;
  localparam logic [2:0] TAG_TOKEN2 = 3'd2;
  localparam logic [2:0] TAG_HOST   = 3'd3;
  localparam logic [2:0] TAG_TYPE   = 3'd4;
  localparam logic [2:0] TAG_CHARSET = 3'd5;
  localparam logic [2:0] TAG_LENGTH = 3'd6;
  localparam logic [2:0] TAG_BODY   = 3'd7;
  localparam logic [2:0] TAG_NONE   = 3'd7;

  // Parser phases; codes 6 and 7 behave as body.
  localparam logic [2:0] PH_TOKEN0 = 3'd0;
  localparam logic [2:0] PH_TOKEN1 = 3'd1;
  localparam logic [2:0] PH_TOKEN2 = 3'd2;
  localparam logic [2:0] PH_HNAME  = 3'd3;
  localparam logic [2:0] PH_HVALUE = 3'd4;
  localparam logic [2:0] PH_BODY   = 3'd5;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Header prefixes, padded with zeros to 16 bytes, first character in the top byte.
  localparam logic [127:0] HOST_TEXT = {"Host: ", {10{8'h00}}};
  localparam logic [127:0] TYPE_TEXT = {"Content-Type: ", {2{8'h00}}};
  localparam logic [127:0] LEN_TEXT  = "Content-Length: ";

  // Prefix slot numbers within the match flags.
  localparam logic [1:0] PFX_HOST = 2'd0;
  localparam logic [1:0] PFX_TYPE = 2'd1;
  localparam logic [1:0] PFX_LEN  = 2'd2;

  localparam logic [9:0] STATUS_MAX = 10'd999;

  typedef struct packed {
    res_kind_e        kind;
    logic [2:0]       tag;
    logic [7:0]       chr;
    logic [31:0]      len;
    logic [9:0]       status;
    logic             last;
  } res_t;

  function automatic logic [7:0] prefix_byte(input logic [1:0] k, input logic [3:0] pos);
    logic [127:0] text;
    begin
      unique case (k)
        PFX_HOST: text = HOST_TEXT;
        PFX_TYPE: text = TYPE_TEXT;
        PFX_LEN:  text = LEN_TEXT;
        default:  text = '0;
      endcase
      prefix_byte = text[8 * (4'd15 - pos) +: 8];
    end
  endfunction

  function automatic logic [4:0] prefix_len(input logic [1:0] k);
    begin
      unique case (k)
        PFX_HOST: prefix_len = 5'd6;
        PFX_TYPE: prefix_len = 5'd14;
        PFX_LEN:  prefix_len = 5'd16;
        default:  prefix_len = 5'd0;
      endcase
    end
  endfunction

  function automatic logic [2:0] prefix_tag(input logic [1:0] k);
    begin
      unique case (k)
        PFX_HOST: prefix_tag = TAG_HOST;
        PFX_TYPE: prefix_tag = TAG_TYPE;
        PFX_LEN:  prefix_tag = TAG_LENGTH;
        default:  prefix_tag = TAG_NONE;
      endcase
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/http_header_field_extractor_core.sv
// Results: each taken byte writes its results into a registered queue that feeds the master side.
// Throughput: one byte per cycle while each byte gives at most one result and the master
// side is ready; a byte that gives two results (a byte result plus the summary, or ';'
// plus its end marker) takes two output beats. A four-entry result queue sets the figure.
// Reset: clears the parser state, sets message_kind to request and empties the queue.
// Top level of the HTTP header field extractor; depends on hhfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module http_header_field_extractor_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,     // message_kind
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [hhfe_pkg::TDATA_IN_BITS-1:0] s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tlast,    // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] field_tag, [10:3] field_char, [42:11] length_value,
  // [52:43] status_value, [55:53] zero
  output logic [hhfe_pkg::TDATA_OUT_BITS-1:0] m_axis_tdata,
  output logic [1:0]       m_axis_tuser,    // [1:0] result_kind
  output logic             m_axis_tlast     // last_of_run
);

  localparam int LB = hhfe_pkg::LENGTH_BITS;

  logic             kind_q;
  logic [2:0]       phase_q, phase_d;
  logic [4:0]       pos_q, pos_d;
  logic [2:0]       flags_q, flags_d;
  logic [2:0]       af_q, af_d;
  logic [1:0]       lbr_q, lbr_d;
  logic [LB-1:0]    len_q, len_d;
  logic [9:0]       st_q, st_d;
  logic             dc_q, dc_d;

  logic             accept;
  logic [7:0]       b;
  logic             eom;
  logic             brk;
  logic             is_digit;
  logic [3:0]       dval;
  logic [LB+3:0]    len_wide;
  logic [LB-1:0]    len_next;
  logic [13:0]      st_wide;
  logic [9:0]       st_next;
  logic [2:0]       flags_eff;
  logic [2:0]       pfx_hit;
  logic [2:0]       pfx_done;
  logic [7:0]       expect_ch;
  logic [63:0]      len_ext;
  logic [31:0]      sum_len;
  logic [9:0]       sum_st;

  logic                 m0_v, m1_v;
  hhfe_pkg::res_kind_e  m0_kind;
  logic [2:0]           m0_tag;
  logic [7:0]           m0_chr;
  hhfe_pkg::res_t       r0, r1, sum_r, m0_r, m1_r;
  logic [1:0]           n_res;

  // Result queue.
  hhfe_pkg::res_t   mem_q [4];
  logic [1:0]       wr_q, rd_q;
  logic [2:0]       cnt_q;
  logic             pop;
  logic [1:0]       push_n;

  assign s_axis_tready = (cnt_q <= 3'd2);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign pop           = m_axis_tvalid & m_axis_tready;

  assign b        = s_axis_tdata[7:0];
  assign eom      = s_axis_tlast;
  assign brk      = (b == hhfe_pkg::CH_CR) || (b == hhfe_pkg::CH_LF);
  assign is_digit = (b >= hhfe_pkg::CH_ZERO) && (b <= hhfe_pkg::CH_NINE);
  assign dval     = 4'(b - hhfe_pkg::CH_ZERO);

  // Decimal steps: x*10 + d built from shifts, saturating at the field maximum.
  assign len_wide = ((LB + 4)'(len_q) << 3) + ((LB + 4)'(len_q) << 1) + (LB + 4)'(dval);
  assign len_next = (|len_wide[LB+3:LB]) ? {LB{1'b1}} : len_wide[LB-1:0];
  assign st_wide  = (14'(st_q) << 3) + (14'(st_q) << 1) + 14'(dval);
  assign st_next  = (st_wide > 14'(hhfe_pkg::STATUS_MAX)) ? hhfe_pkg::STATUS_MAX
                                                           : st_wide[9:0];

  // Host is matched only in requests.
  assign flags_eff = kind_q ? (flags_q & 3'b110) : flags_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pfx_hit[k]  = flags_eff[k] && (pos_q < hhfe_pkg::prefix_len(2'(k))) &&
                    (hhfe_pkg::prefix_byte(2'(k), pos_q[3:0]) == b);
      pfx_done[k] = pfx_hit[k] && (pos_q == hhfe_pkg::prefix_len(2'(k)) - 5'd1);
    end
  end

  // The blank line is CR LF CR LF; even positions expect CR.
  assign expect_ch = lbr_q[0] ? hhfe_pkg::CH_LF : hhfe_pkg::CH_CR;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    flags_d = flags_q;
    af_d    = af_q;
    lbr_d   = lbr_q;
    len_d   = len_q;
    st_d    = st_q;
    dc_d    = dc_q;
    m0_v    = 1'b0;
    m0_kind = hhfe_pkg::RES_BYTE;
    m0_tag  = hhfe_pkg::TAG_TOKEN0;
    m0_chr  = b;
    m1_v    = 1'b0;
    len_ext = '0;
    sum_len = '0;
    sum_st  = '0;

    unique case (phase_q)
      hhfe_pkg::PH_TOKEN0: begin
        if (brk || b == hhfe_pkg::CH_SPACE) begin
          m0_v    = !eom;
          m0_kind = hhfe_pkg::RES_END;
          m0_tag  = hhfe_pkg::TAG_TOKEN0;
          if (brk) begin
            phase_d = hhfe_pkg::PH_HNAME;
            pos_d   = '0;
            flags_d = 3'b111;
            af_d    = hhfe_pkg::TAG_NONE;
          end else begin
            phase_d = hhfe_pkg::PH_TOKEN1;
            dc_d    = 1'b0;
          end
        end else begin
          m0_v   = 1'b1;
          m0_tag = hhfe_pkg::TAG_TOKEN0;
        end
      end
      hhfe_pkg::PH_TOKEN1: begin
        if (brk || b == hhfe_pkg::CH_SPACE) begin
          // Responses carry the status code here, which is never tagged.
          m0_v    = !eom && !kind_q;
          m0_kind = hhfe_pkg::RES_END;
          m0_tag  = hhfe_pkg::TAG_TOKEN1;
          if (brk) begin
            phase_d = hhfe_pkg::PH_HNAME;
            pos_d   = '0;
            flags_d = 3'b111;
            af_d    = hhfe_pkg::TAG_NONE;
          end else begin
            phase_d = hhfe_pkg::PH_TOKEN2;
          end
        end else if (kind_q) begin
          if (!dc_q) begin
            if (is_digit) st_d = st_next;
            else          dc_d = 1'b1;
          end
        end else begin
          m0_v   = 1'b1;
          m0_tag = hhfe_pkg::TAG_TOKEN1;
        end
      end
      hhfe_pkg::PH_TOKEN2: begin
        m0_tag = hhfe_pkg::TAG_TOKEN2;
        if (brk) begin
          m0_v    = !eom;
          m0_kind = hhfe_pkg::RES_END;
          phase_d = hhfe_pkg::PH_HNAME;
          pos_d   = '0;
          flags_d = 3'b111;
          af_d    = hhfe_pkg::TAG_NONE;
        end else begin
          m0_v = 1'b1;
        end
      end
      hhfe_pkg::PH_HNAME: begin
        if (brk) begin
          pos_d   = '0;
          flags_d = 3'b111;
          af_d    = hhfe_pkg::TAG_NONE;
        end else begin
          flags_d = pfx_hit;
          pos_d   = (&pos_q) ? pos_q : pos_q + 5'd1;
          for (int k = 0; k < 3; k++) begin
            if (pfx_done[k]) begin
              phase_d = hhfe_pkg::PH_HVALUE;
              af_d    = hhfe_pkg::prefix_tag(2'(k));
              if (2'(k) == hhfe_pkg::PFX_LEN) begin
                len_d = '0;
                dc_d  = 1'b0;
              end
            end
          end
        end
      end
      hhfe_pkg::PH_HVALUE: begin
        m0_tag = af_q;
        if (brk) begin
          m0_v    = !eom && (af_q >= hhfe_pkg::TAG_HOST) && (af_q <= hhfe_pkg::TAG_LENGTH);
          m0_kind = hhfe_pkg::RES_END;
          phase_d = hhfe_pkg::PH_HNAME;
          pos_d   = '0;
          flags_d = 3'b111;
          af_d    = hhfe_pkg::TAG_NONE;
        end else begin
          unique case (af_q)
            hhfe_pkg::TAG_HOST: m0_v = 1'b1;
            hhfe_pkg::TAG_TYPE: begin
              m0_v = 1'b1;
              // In responses the media type ends at ';' and the charset follows.
              if (kind_q && b == hhfe_pkg::CH_SEMI) begin
                m1_v = !eom;
                af_d = hhfe_pkg::TAG_CHARSET;
              end
            end
            hhfe_pkg::TAG_CHARSET: m0_v = (b != hhfe_pkg::CH_SPACE);
            hhfe_pkg::TAG_LENGTH: begin
              m0_v = 1'b1;
              if (!dc_q) begin
                if (is_digit) len_d = len_next;
                else          dc_d  = 1'b1;
              end
            end
            default: m0_v = 1'b0;
          endcase
        end
      end
      default: begin
        m0_v   = 1'b1;
        m0_tag = hhfe_pkg::TAG_BODY;
      end
    endcase

    if (phase_q < hhfe_pkg::PH_BODY) begin
      if (b == expect_ch) begin
        if (lbr_q == 2'd3) begin
          phase_d = hhfe_pkg::PH_BODY;
          lbr_d   = '0;
          af_d    = hhfe_pkg::TAG_NONE;
        end else begin
          lbr_d = lbr_q + 2'd1;
        end
      end else begin
        lbr_d = (b == hhfe_pkg::CH_CR) ? 2'd1 : 2'd0;
      end
    end

    // The summary reports the values after this byte, before the message state clears.
    len_ext = 64'(len_d);
    sum_len = (|len_ext[63:32]) ? 32'hFFFF_FFFF : len_ext[31:0];
    sum_st  = st_d;

    if (eom) begin
      phase_d = hhfe_pkg::PH_TOKEN0;
      pos_d   = '0;
      flags_d = 3'b111;
      af_d    = hhfe_pkg::TAG_NONE;
      lbr_d   = '0;
      len_d   = '0;
      st_d    = '0;
      dc_d    = 1'b0;
    end
  end

  // Assemble up to two results in order: main results first, summary last.
  always_comb begin
    m0_r        = '0;
    m0_r.kind   = m0_kind;
    m0_r.tag    = m0_tag;
    m0_r.chr    = (m0_kind == hhfe_pkg::RES_BYTE) ? m0_chr : 8'h00;
    m1_r        = '0;
    m1_r.kind   = hhfe_pkg::RES_END;
    m1_r.tag    = hhfe_pkg::TAG_TYPE;
    sum_r        = '0;
    sum_r.kind   = hhfe_pkg::RES_SUMMARY;
    sum_r.len    = sum_len;
    sum_r.status = sum_st;
    sum_r.last   = 1'b1;
    r0 = '0;
    r1 = '0;
    n_res = 2'd0;
    if (m0_v) begin
      r0 = m0_r;
      if (m1_v) begin
        r1      = m1_r;
        r1.last = 1'b1;
        n_res   = 2'd2;
      end else if (eom) begin
        r1    = sum_r;
        n_res = 2'd2;
      end else begin
        r0.last = 1'b1;
        n_res   = 2'd1;
      end
    end else if (eom) begin
      r0    = sum_r;
      n_res = 2'd1;
    end
  end

  // The mode register takes a write at any edge; parser state moves only on a taken beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= 1'b0;
      phase_q <= hhfe_pkg::PH_TOKEN0;
      pos_q   <= '0;
      flags_q <= 3'b111;
      af_q    <= hhfe_pkg::TAG_NONE;
      lbr_q   <= '0;
      len_q   <= '0;
      st_q    <= '0;
      dc_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        kind_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        flags_q <= flags_d;
        af_q    <= af_d;
        lbr_q   <= lbr_d;
        len_q   <= len_d;
        st_q    <= st_d;
        dc_q    <= dc_d;
      end
    end
  end

  assign push_n = accept ? n_res : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_n;
      rd_q  <= rd_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_n) - 3'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= r0;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_q + 2'd1] <= r1;
    end
  end

  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tuser  = mem_q[rd_q].kind;
  assign m_axis_tlast  = mem_q[rd_q].last;
  assign m_axis_tdata  = {3'b000, mem_q[rd_q].status, mem_q[rd_q].len,
                          mem_q[rd_q].chr, mem_q[rd_q].tag};

endmodule

`default_nettype wire

FILE: hdl/hhfe_checker.sv
// Port-level checker for the HTTP header field extractor, bound to the top level.
// Depends on hhfe_pkg for the result kind codes.
`timescale 1ns / 1ps
`default_nettype none

module hhfe_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [hhfe_pkg::TDATA_OUT_BITS-1:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // A stalled output beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // The summary is always the final result of its byte.
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == hhfe_pkg::RES_SUMMARY |-> m_axis_tlast)
    else $error("summary without last flag");

  // Only the summary carries length and status.
  a_values_only_in_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != hhfe_pkg::RES_SUMMARY |-> m_axis_tdata[52:11] == '0)
    else $error("length or status outside summary");

  // End markers and summaries carry no character, and on those beats the pad bits stay zero.
  a_no_char_on_markers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != hhfe_pkg::RES_BYTE |->
      m_axis_tdata[10:3] == 8'h00 && m_axis_tdata[55:53] == 3'b000)
    else $error("character on a marker or summary beat");

endmodule

bind http_header_field_extractor_core hhfe_port_checker u_hhfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: verif/hhfe_checker.sv
// Checker for the HTTP header field extractor: watches the configuration port and both
// stream channels, predicts every result beat and compares it with what the block sends.
// Depends on hhfe_pkg for the result record, the code values and the widths.
`timescale 1ns / 1ps

module hhfe_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic                                s_valid_i,
  input  logic                                s_ready_i,
  input  logic [hhfe_pkg::TDATA_IN_BITS-1:0]  s_data_i,
  input  logic                                s_last_i,
  input  logic                                m_valid_i,
  input  logic                                m_ready_i,
  input  logic [hhfe_pkg::TDATA_OUT_BITS-1:0] m_data_i,
  input  logic [1:0]                          m_user_i,
  input  logic                                m_last_i,
  output int                                  errors_o,
  output int                                  pending_o
);

  logic                             resp_mode;
  logic [2:0]                       phase_q;
  logic [4:0]                       col_q;
  logic [2:0]                       name_hits_q;
  logic [2:0]                       field_q;
  logic [1:0]                       crlf_run_q;
  logic [hhfe_pkg::LENGTH_BITS-1:0] clen_q;
  logic [9:0]                       status_q;
  logic                             num_done_q;
  logic                             final_byte;

  hhfe_pkg::res_t byte_results[$];  // beats caused by the byte being tagged
  hhfe_pkg::res_t due_results[$];   // beats still owed by the block, oldest first

  function automatic string name_text(input int k);
    case (k)
      hhfe_pkg::PFX_HOST: return "Host: ";
      hhfe_pkg::PFX_TYPE: return "Content-Type: ";
      default:            return "Content-Length: ";
    endcase
  endfunction

  function automatic logic [2:0] name_tag(input int k);
    case (k)
      hhfe_pkg::PFX_HOST: return hhfe_pkg::TAG_HOST;
      hhfe_pkg::PFX_TYPE: return hhfe_pkg::TAG_TYPE;
      default:            return hhfe_pkg::TAG_LENGTH;
    endcase
  endfunction

  task automatic clear_parser();
    phase_q     = hhfe_pkg::PH_TOKEN0;
    col_q       = '0;
    name_hits_q = 3'b111;
    field_q     = hhfe_pkg::TAG_NONE;
    crlf_run_q  = '0;
    clen_q      = '0;
    status_q    = '0;
    num_done_q  = 1'b0;
  endtask

  task automatic emit(input hhfe_pkg::res_kind_e k, input logic [2:0] tag,
                      input logic [7:0] chr, input logic [31:0] len,
                      input logic [9:0] status);
    hhfe_pkg::res_t r;
    if (byte_results.size() < 2) begin
      r.kind   = k;
      r.tag    = tag;
      r.chr    = chr;
      r.len    = len;
      r.status = status;
      r.last   = 1'b0;
      byte_results.push_back(r);
    end
  endtask

  // The final byte of a message never gets an end marker; the summary closes the field.
  task automatic close_field(input logic [2:0] tag);
    if (!final_byte) emit(hhfe_pkg::RES_END, tag, '0, '0, '0);
  endtask

  task automatic new_line();
    phase_q     = hhfe_pkg::PH_HNAME;
    col_q       = '0;
    name_hits_q = 3'b111;
    field_q     = hhfe_pkg::TAG_NONE;
  endtask

  task automatic length_digit(input logic [7:0] b);
    logic [hhfe_pkg::LENGTH_BITS+3:0] grown;
    if (!num_done_q) begin
      if (b < hhfe_pkg::CH_ZERO || b > hhfe_pkg::CH_NINE) begin
        num_done_q = 1'b1;
      end else begin
        grown  = clen_q * 10 + (b - hhfe_pkg::CH_ZERO);
        clen_q = (grown > {hhfe_pkg::LENGTH_BITS{1'b1}}) ? '1
                                                          : grown[hhfe_pkg::LENGTH_BITS-1:0];
      end
    end
  endtask

  task automatic status_digit(input logic [7:0] b);
    int v;
    if (!num_done_q) begin
      if (b < hhfe_pkg::CH_ZERO || b > hhfe_pkg::CH_NINE) begin
        num_done_q = 1'b1;
      end else begin
        v        = status_q * 10 + (b - hhfe_pkg::CH_ZERO);
        status_q = (v > hhfe_pkg::STATUS_MAX) ? hhfe_pkg::STATUS_MAX : v[9:0];
      end
    end
  endtask

  task automatic match_name(input logic [7:0] b);
    string txt;
    int    p;
    int    k;
    p = col_q;
    // Host is a request header only.
    if (resp_mode) name_hits_q[hhfe_pkg::PFX_HOST] = 1'b0;
    for (k = 0; k < 3; k++) begin
      txt = name_text(k);
      if (name_hits_q[k]) begin
        if (p >= txt.len() || txt[p] != b) begin
          name_hits_q[k] = 1'b0;
        end else if (p + 1 == txt.len()) begin
          phase_q = hhfe_pkg::PH_HVALUE;
          field_q = name_tag(k);
          if (field_q == hhfe_pkg::TAG_LENGTH) begin
            clen_q     = '0;
            num_done_q = 1'b0;
          end
        end
      end
    end
    col_q = (p < 31) ? 5'(p + 1) : 5'd31;
  endtask

  task automatic value_byte(input logic [7:0] b);
    case (field_q)
      hhfe_pkg::TAG_HOST: emit(hhfe_pkg::RES_BYTE, hhfe_pkg::TAG_HOST, b, '0, '0);
      hhfe_pkg::TAG_TYPE: begin
        emit(hhfe_pkg::RES_BYTE, hhfe_pkg::TAG_TYPE, b, '0, '0);
        // In responses the media type stops at the first ';' and charset follows.
        if (resp_mode && b == hhfe_pkg::CH_SEMI) begin
          close_field(hhfe_pkg::TAG_TYPE);
          field_q = hhfe_pkg::TAG_CHARSET;
        end
      end
      hhfe_pkg::TAG_CHARSET: begin
        if (b != hhfe_pkg::CH_SPACE)
          emit(hhfe_pkg::RES_BYTE, hhfe_pkg::TAG_CHARSET, b, '0, '0);
      end
      hhfe_pkg::TAG_LENGTH: begin
        emit(hhfe_pkg::RES_BYTE, hhfe_pkg::TAG_LENGTH, b, '0, '0);
        length_digit(b);
      end
      default: ;
    endcase
  endtask

  task automatic tag_http_byte(input logic [7:0] b, input logic eom);
    logic           brk;
    logic           in_hdr;
    hhfe_pkg::res_t r;
    brk        = (b == hhfe_pkg::CH_CR) || (b == hhfe_pkg::CH_LF);
    in_hdr     = (phase_q < hhfe_pkg::PH_BODY);
    final_byte = eom;
    byte_results.delete();

    case (phase_q)
      hhfe_pkg::PH_TOKEN0: begin
        if (brk) begin
          close_field(hhfe_pkg::TAG_TOKEN0);
          new_line();
        end else if (b == hhfe_pkg::CH_SPACE) begin
          close_field(hhfe_pkg::TAG_TOKEN0);
          phase_q    = hhfe_pkg::PH_TOKEN1;
          num_done_q = 1'b0;
        end else begin
          emit(hhfe_pkg::RES_BYTE, hhfe_pkg::TAG_TOKEN0, b, '0, '0);
        end
      end
      hhfe_pkg::PH_TOKEN1: begin
        // The response status token is converted, not tagged.
        if (brk) begin
          if (!resp_mode) close_field(hhfe_pkg::TAG_TOKEN1);
          new_line();
        end else if (b == hhfe_pkg::CH_SPACE) begin
          if (!resp_mode) close_field(hhfe_pkg::TAG_TOKEN1);
          phase_q = hhfe_pkg::PH_TOKEN2;
        end else if (resp_mode) begin
          status_digit(b);
        end else begin
          emit(hhfe_pkg::RES_BYTE, hhfe_pkg::TAG_TOKEN1, b, '0, '0);
        end
      end
      hhfe_pkg::PH_TOKEN2: begin
        if (brk) begin
          close_field(hhfe_pkg::TAG_TOKEN2);
          new_line();
        end else begin
          emit(hhfe_pkg::RES_BYTE, hhfe_pkg::TAG_TOKEN2, b, '0, '0);
        end
      end
      hhfe_pkg::PH_HNAME: begin
        if (brk) new_line();
        else match_name(b);
      end
      hhfe_pkg::PH_HVALUE: begin
        if (brk) begin
          if (field_q >= hhfe_pkg::TAG_HOST && field_q <= hhfe_pkg::TAG_LENGTH)
            close_field(field_q);
          new_line();
        end else begin
          value_byte(b);
        end
      end
      default: emit(hhfe_pkg::RES_BYTE, hhfe_pkg::TAG_BODY, b, '0, '0);
    endcase

    // Track CR LF CR LF; everything after it is body.
    if (in_hdr) begin
      if (b == (crlf_run_q[0] ? hhfe_pkg::CH_LF : hhfe_pkg::CH_CR)) begin
        if (crlf_run_q == 2'd3) begin
          phase_q    = hhfe_pkg::PH_BODY;
          crlf_run_q = '0;
          field_q    = hhfe_pkg::TAG_NONE;
        end else begin
          crlf_run_q = crlf_run_q + 2'd1;
        end
      end else begin
        crlf_run_q = (b == hhfe_pkg::CH_CR) ? 2'd1 : 2'd0;
      end
    end

    if (eom) begin
      emit(hhfe_pkg::RES_SUMMARY, hhfe_pkg::TAG_TOKEN0, '0,
           (clen_q > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(clen_q), status_q);
      clear_parser();
    end

    if (byte_results.size() > 0) begin
      r      = byte_results.pop_back();
      r.last = 1'b1;
      byte_results.push_back(r);
    end
    while (byte_results.size() > 0) due_results.push_back(byte_results.pop_front());
  endtask

  task automatic check_result();
    hhfe_pkg::res_t got;
    hhfe_pkg::res_t want;
    got.kind   = hhfe_pkg::res_kind_e'(m_user_i);
    got.tag    = m_data_i[2:0];
    got.chr    = m_data_i[10:3];
    got.len    = m_data_i[42:11];
    got.status = m_data_i[52:43];
    got.last   = m_last_i;
    if (due_results.size() == 0) begin
      errors_o = errors_o + 1;
      if (errors_o <= 10)
        $display("%0t: result beat with nothing expected: kind=%0d tag=%0d char=%02h",
                 $time, got.kind, got.tag, got.chr);
    end else begin
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.tag !== want.tag || got.chr !== want.chr ||
          got.len !== want.len || got.status !== want.status || got.last !== want.last ||
          m_data_i[hhfe_pkg::TDATA_OUT_BITS-1:53] !== '0) begin
        errors_o = errors_o + 1;
        if (errors_o <= 10)
          $display("%0t: mismatch: expected kind=%0d tag=%0d char=%02h len=%0d st=%0d ",
                   $time, want.kind, want.tag, want.chr, want.len, want.status,
                   "last=%0d, got kind=%0d tag=%0d char=%02h len=%0d st=%0d ",
                   want.last, got.kind, got.tag, got.chr, got.len, got.status,
                   "last=%0d pad=%0h",
                   got.last, m_data_i[hhfe_pkg::TDATA_OUT_BITS-1:53]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_mode = 1'b0;
      clear_parser();
      due_results.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) resp_mode = cfg_wdata_i;
      // A result beat never belongs to a byte taken at the same edge.
      if (m_valid_i && m_ready_i) check_result();
      if (s_valid_i && s_ready_i) tag_http_byte(s_data_i[7:0], s_last_i);
      pending_o = due_results.size();
    end
  end

endmodule

FILE: verif/tb.sv
// Top of the HTTP header field extractor testbench: clock, reset, message stimulus,
// random stalls on both channels, watchdog and verdict. Checking is in hhfe_checker.
// Depends on hhfe_pkg, hhfe_checker and http_header_field_extractor_core.
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT    = 3000;
  localparam int BYTES_PER_MODE = 200;

  logic                                clk_i;
  logic                                rst_ni        = 1'b0;
  logic                                cfg_we_i      = 1'b0;
  logic                                cfg_wdata_i   = 1'b0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [hhfe_pkg::TDATA_IN_BITS-1:0]  s_axis_tdata  = '0;
  logic                                s_axis_tlast  = 1'b0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [hhfe_pkg::TDATA_OUT_BITS-1:0] m_axis_tdata;
  logic [1:0]                          m_axis_tuser;
  logic                                m_axis_tlast;

  int   errors;
  int   pending;
  int   bytes_sent   = 0;
  int   quiet_cycles = 0;
  int   sink_hold    = 0;
  bit   src_gaps     = 1'b0;
  bit   sink_gaps    = 1'b0;
  logic resp_mode    = 1'b0;

  logic [7:0] msg_bytes[$];

  http_header_field_extractor_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  hhfe_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_user_i    (m_axis_tuser),
    .m_last_i    (m_axis_tlast),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short stalls, now and then a long one.
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_hold > 0) begin
        m_axis_tready = 1'b0;
        sink_hold--;
      end else if (sink_gaps && $urandom_range(0, 99) < 25) begin
        m_axis_tready = 1'b0;
        sink_hold     = stall_len() - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int idle;
    if (src_gaps && $urandom_range(0, 99) < 25) begin
      idle          = stall_len();
      s_axis_tvalid = 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = eom;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    bytes_sent++;
  endtask

  task automatic send_msg();
    int i;
    for (i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
    // A byte that gives no result may still be in flight.
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic v);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    resp_mode   = v;
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  task automatic add_token(input int max_len);
    repeat ($urandom_range(0, max_len)) msg_bytes.push_back(8'($urandom_range(33, 126)));
  endtask

  task automatic add_spaced(input int max_len);
    repeat ($urandom_range(0, max_len)) begin
      if ($urandom_range(0, 4) == 0) msg_bytes.push_back(hhfe_pkg::CH_SPACE);
      else msg_bytes.push_back(8'($urandom_range(33, 126)));
    end
  endtask

  task automatic add_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi))
      msg_bytes.push_back(8'(hhfe_pkg::CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic add_eol();
    case ($urandom_range(0, 9))
      7: msg_bytes.push_back(hhfe_pkg::CH_LF);
      8: msg_bytes.push_back(hhfe_pkg::CH_CR);
      9: begin
        msg_bytes.push_back(hhfe_pkg::CH_LF);
        msg_bytes.push_back(hhfe_pkg::CH_CR);
      end
      default: begin
        msg_bytes.push_back(hhfe_pkg::CH_CR);
        msg_bytes.push_back(hhfe_pkg::CH_LF);
      end
    endcase
  endtask

  task automatic add_header_line();
    string nm;
    case ($urandom_range(0, 6))
      0: begin
        add_text("Host: ");
        add_spaced(6);
      end
      1: begin
        add_text("Content-Type: ");
        add_token(5);
        if ($urandom_range(0, 2) != 0) begin
          msg_bytes.push_back(hhfe_pkg::CH_SEMI);
          add_spaced(8);
        end
      end
      2: begin
        add_text("Content-Length: ");
        if ($urandom_range(0, 3) == 0) add_digits(9, 12);
        else add_digits(0, 5);
        if ($urandom_range(0, 2) == 0) add_token(3);
      end
      3: begin
        // A name that breaks off partway through a known prefix.
        case ($urandom_range(0, 2))
          0: nm = "Host: ";
          1: nm = "Content-Type: ";
          default: nm = "Content-Length: ";
        endcase
        add_text(nm.substr(0, $urandom_range(0, nm.len() - 2)));
        add_token(4);
      end
      4: begin
        add_text("X-");
        add_token(5);
        add_text(": ");
        add_spaced(5);
      end
      5: begin
        add_text("Content-Length: ");
        msg_bytes.push_back(hhfe_pkg::CH_SPACE);
        add_digits(1, 4);
      end
      default: repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom));
    endcase
    add_eol();
  endtask

  task automatic send_message();
    int cut;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
    end else begin
      if (resp_mode) begin
        if ($urandom_range(0, 3) != 0) add_text("HTTP/1.1");
        else add_token(5);
      end else begin
        case ($urandom_range(0, 3))
          0: add_text("GET");
          1: add_text("POST");
          2: add_text("HEAD");
          default: add_token(5);
        endcase
      end
      // Now and then the start line ends before all three tokens.
      if ($urandom_range(0, 9) != 0) begin
        msg_bytes.push_back(hhfe_pkg::CH_SPACE);
        if (resp_mode) begin
          add_digits(0, 5);
          if ($urandom_range(0, 4) == 0) add_token(2);
        end else begin
          add_text("/");
          add_token(6);
        end
        if ($urandom_range(0, 9) != 0) begin
          msg_bytes.push_back(hhfe_pkg::CH_SPACE);
          if (resp_mode) add_spaced(6);
          else add_text("HTTP/1.1");
        end
      end
      add_eol();
      repeat ($urandom_range(0, 4)) add_header_line();
      if ($urandom_range(0, 7) != 0) msg_bytes.push_back(hhfe_pkg::CH_CR);
      msg_bytes.push_back(hhfe_pkg::CH_LF);
      repeat ($urandom_range(0, 8)) msg_bytes.push_back(8'($urandom));
    end
    // Broken sequences: the message ends early.
    if (msg_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
    send_msg();
  endtask

  initial begin
    int   mode_idx;
    int   stop_at;
    logic mode_seq[4];
    bit   src_seq[4];
    bit   sink_seq[4];

    mode_seq = '{1'b0, 1'b1, 1'b1, 1'b0};
    src_seq  = '{1'b1, 1'b1, 1'b0, 1'b0};
    sink_seq = '{1'b1, 1'b0, 1'b1, 1'b0};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Request: empty path token, Host with extreme byte values, blank line, one body byte.
    write_mode(1'b0);
    add_text("A  B");
    msg_bytes.push_back(hhfe_pkg::CH_CR);
    msg_bytes.push_back(hhfe_pkg::CH_LF);
    add_text("Host: ");
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(hhfe_pkg::CH_CR);
    msg_bytes.push_back(hhfe_pkg::CH_LF);
    msg_bytes.push_back(hhfe_pkg::CH_CR);
    msg_bytes.push_back(hhfe_pkg::CH_LF);
    add_text("Z");
    send_msg();

    // Response: status beyond 999, then a type that ends on ';' and a spaced charset.
    write_mode(1'b1);
    add_text("V 1234");
    msg_bytes.push_back(hhfe_pkg::CH_LF);
    add_text("Content-Type: ; x");
    send_msg();

    for (mode_idx = 0; mode_idx < 4; mode_idx++) begin
      write_mode(mode_seq[mode_idx]);
      src_gaps  = src_seq[mode_idx];
      sink_gaps = sink_seq[mode_idx];
      stop_at   = bytes_sent + BYTES_PER_MODE;
      while (bytes_sent < stop_at) begin
        send_message();
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    sink_gaps = 1'b1;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
hdl/hhfe_pkg.sv
hdl/http_header_field_extractor_core.sv
hdl/hhfe_checker.sv
verif/hhfe_checker.sv
verif/tb.sv
